// File: src/lpg_pkg.sv
package lpg_pkg;

   // Field widths
   localparam int COORD_BITS = 12;
   localparam int SPAN_BITS  = COORD_BITS;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int COLOR_BITS = 16;

   // Function codes
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [SPAN_BITS-1:0]  span_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic        [COLOR_BITS-1:0] color_type;

   // One input transaction
   typedef struct packed {
      logic      func;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      color_type line_color;
   } req_type;

   // One result transaction
   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } pix_type;

   // Core status toward the pipeline control
   typedef struct packed {
      logic busy;      // line in progress
      logic produces;  // held item yields a pixel
   } status_type;

endpackage

// File: src/lpg_input_reg.sv
module lpg_input_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  lpg_pkg::req_type in_item,
   input  logic             take,
   output logic             held_valid,
   output lpg_pkg::req_type held_item
);
   import lpg_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    accept;

   // Stall only while a held transaction cannot move on
   assign in_stall = valid_ff && !take;
   assign accept   = in_valid && !in_stall;

   assign valid_in = accept ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// File: src/lpg_core.sv
module lpg_core (
   input  logic                clock,
   input  logic                reset,
   input  lpg_pkg::req_type    item,
   input  logic                fire,
   output lpg_pkg::pix_type    pixel,
   output lpg_pkg::status_type status
);
   import lpg_pkg::*;

   localparam coord_type COORD_ONE = coord_type'(1);
   localparam coord_type COORD_NEG = coord_type'(-1);

   typedef logic signed [COORD_BITS:0] diff_type;
   typedef logic signed [ERR_BITS:0]   dbl_type;

   // Line state
   logic      busy_ff, busy_in;
   logic      axis_ff, axis_in;
   coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   span_type  span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic      neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   err_type   err_ff, err_in;
   color_type color_ff, color_in;

   // Start decode
   diff_type  dx, dy;
   logic      s_neg_x, s_neg_y;
   span_type  s_span_x, s_span_y;
   logic      s_axis;
   err_type   s_err;

   // Walk decode
   dbl_type   e2, neg_sy, sx_w;
   logic      go_x, go_y;
   err_type   sx_e, sy_e;

   assign dx = diff_type'(item.x_end) - diff_type'(item.x_start);
   assign dy = diff_type'(item.y_end) - diff_type'(item.y_start);
   assign s_neg_x  = item.x_end < item.x_start;
   assign s_neg_y  = item.y_end < item.y_start;
   assign s_span_x = s_neg_x ? span_type'(-dx) : span_type'(dx);
   assign s_span_y = s_neg_y ? span_type'(-dy) : span_type'(dy);
   assign s_axis   = (item.x_start == item.x_end) || (item.y_start == item.y_end);
   assign s_err    = err_type'({2'b00, s_span_x}) - err_type'({2'b00, s_span_y});

   // Bresenham decision: e2 = 2*err against -span_y and span_x
   assign e2     = {err_ff, 1'b0};
   assign sx_w   = dbl_type'({3'b000, span_x_ff});
   assign neg_sy = -dbl_type'({3'b000, span_y_ff});
   assign go_x   = e2 > neg_sy;
   assign go_y   = e2 < sx_w;
   assign sx_e   = err_type'({2'b00, span_x_ff});
   assign sy_e   = err_type'({2'b00, span_y_ff});

   // Next state and pixel
   always_comb begin
      busy_in   = busy_ff;
      axis_in   = axis_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      stop_x_in = stop_x_ff;
      stop_y_in = stop_y_ff;
      span_x_in = span_x_ff;
      span_y_in = span_y_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      err_in    = err_ff;
      color_in  = color_ff;
      pixel     = '{x: cur_x_ff, y: cur_y_ff, color: color_ff, last: 1'b0};
      status.busy     = busy_ff;
      status.produces = 1'b0;

      if (item.func == FUNC_START) begin
         status.produces = 1'b1;
         color_in  = item.line_color;
         neg_x_in  = s_neg_x;
         neg_y_in  = s_neg_y;
         span_x_in = s_span_x;
         span_y_in = s_span_y;
         if (s_axis) begin
            // straight line runs from the smaller coordinate
            axis_in   = 1'b1;
            cur_x_in  = s_neg_x ? item.x_end   : item.x_start;
            stop_x_in = s_neg_x ? item.x_start : item.x_end;
            cur_y_in  = s_neg_y ? item.y_end   : item.y_start;
            stop_y_in = s_neg_y ? item.y_start : item.y_end;
            err_in    = '0;
            busy_in   = !((cur_x_in == stop_x_in) && (cur_y_in == stop_y_in));
            pixel     = '{x: cur_x_in, y: cur_y_in, color: item.line_color,
                          last: !busy_in};
         end else begin
            // sloped line shows its end point first
            axis_in   = 1'b0;
            cur_x_in  = item.x_start;
            cur_y_in  = item.y_start;
            stop_x_in = item.x_end;
            stop_y_in = item.y_end;
            err_in    = s_err;
            busy_in   = 1'b1;
            pixel     = '{x: item.x_end, y: item.y_end, color: item.line_color,
                          last: 1'b0};
         end
      end else if (busy_ff) begin
         status.produces = 1'b1;
         if (axis_ff) begin
            if (cur_x_ff != stop_x_ff) begin
               cur_x_in = cur_x_ff + COORD_ONE;
            end else begin
               cur_y_in = cur_y_ff + COORD_ONE;
            end
            busy_in = !((cur_x_in == stop_x_ff) && (cur_y_in == stop_y_ff));
            pixel   = '{x: cur_x_in, y: cur_y_in, color: color_ff, last: !busy_in};
         end else begin
            // emit the current point, then step
            err_in = err_ff - (go_x ? sy_e : '0) + (go_y ? sx_e : '0);
            if (go_x) begin
               cur_x_in = cur_x_ff + (neg_x_ff ? COORD_NEG : COORD_ONE);
            end
            if (go_y) begin
               cur_y_in = cur_y_ff + (neg_y_ff ? COORD_NEG : COORD_ONE);
            end
            busy_in = !((cur_x_in == stop_x_ff) && (cur_y_in == stop_y_ff));
            pixel   = '{x: cur_x_ff, y: cur_y_ff, color: color_ff, last: !busy_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         axis_ff   <= 1'b0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         stop_x_ff <= '0;
         stop_y_ff <= '0;
         span_x_ff <= '0;
         span_y_ff <= '0;
         neg_x_ff  <= 1'b0;
         neg_y_ff  <= 1'b0;
         err_ff    <= '0;
         color_ff  <= '0;
      end else if (fire) begin
         busy_ff   <= busy_in;
         axis_ff   <= axis_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         stop_x_ff <= stop_x_in;
         stop_y_ff <= stop_y_in;
         span_x_ff <= span_x_in;
         span_y_ff <= span_y_in;
         neg_x_ff  <= neg_x_in;
         neg_y_ff  <= neg_y_in;
         err_ff    <= err_in;
         color_ff  <= color_in;
      end
   end

endmodule

// File: src/line_pixel_generator.sv
// A request is taken into the input register; the single-pass step of lpg_core
// (compares and adds) then writes its pixel into the result register.
// Throughput: one request per cycle while rsp_stall does not hold a pixel back.
// Reset: synchronous, active high; clears the line state, so an advance right
// after reset gives no pixel; both channels come up empty.
module line_pixel_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  lpg_pkg::coord_type req_x_start,
   input  lpg_pkg::coord_type req_y_start,
   input  lpg_pkg::coord_type req_x_end,
   input  lpg_pkg::coord_type req_y_end,
   input  lpg_pkg::color_type req_line_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lpg_pkg::coord_type rsp_pixel_x,
   output lpg_pkg::coord_type rsp_pixel_y,
   output lpg_pkg::color_type rsp_pixel_color,
   output logic               rsp_last_pixel
);
   import lpg_pkg::*;

   req_type    in_item, held_item;
   logic       held_valid, take, fire, out_free, load;
   pix_type    pixel;
   status_type status;

   logic       rsp_valid_ff, rsp_valid_in;
   pix_type    rsp_ff;

   assign in_item = '{func: req_func, x_start: req_x_start, y_start: req_y_start,
                      x_end: req_x_end, y_end: req_y_end, line_color: req_line_color};

   // Input register
   lpg_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_item    (in_item),
      .take       (take),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   // Line state and step logic
   lpg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .item   (held_item),
      .fire   (fire),
      .pixel  (pixel),
      .status (status)
   );

   // Held transaction moves on when the result register can take its pixel, or when it yields none
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = out_free || !status.produces;
   assign fire     = held_valid && take;
   assign load     = fire && status.produces;

   // Result register
   assign rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= pixel;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_ff.x;
   assign rsp_pixel_y     = rsp_ff.y;
   assign rsp_pixel_color = rsp_ff.color;
   assign rsp_last_pixel  = rsp_ff.last;

   // A start always yields a pixel
   a_start_yields: assert property (@(posedge clock) disable iff (reset)
      (fire && held_item.func == FUNC_START) |=> rsp_valid)
      else $error("start transaction produced no pixel");

   // The last pixel of a line leaves the core idle
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (load && pixel.last) |=> !status.busy)
      else $error("line still busy after last pixel");

   // A pixel is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load)
      else $error("result register overwritten while stalled");

   // Advance while idle passes through without a pixel
   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && held_item.func == FUNC_ADVANCE && !status.busy) |-> !load)
      else $error("pixel produced while idle");

endmodule

// File: dv/tb_line_pixel_generator.sv
module tb_line_pixel_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import lpg_pkg::*;

   localparam int RANDOM_ITEMS = 1450;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   // One queued request; hold_off makes the driver wait for all pixels first
   typedef struct {
      req_type req;
      bit      hold_off;
   } stim_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   logic      req_func = FUNC_ADVANCE;
   coord_type req_x_start = '0;
   coord_type req_y_start = '0;
   coord_type req_x_end = '0;
   coord_type req_y_end = '0;
   color_type req_line_color = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   color_type rsp_pixel_color;
   logic      rsp_last_pixel;

   stim_type pending_reqs[$];
   pix_type  expected_pixels[$];
   int       error_count = 0;
   int       quiet_cycles = 0;
   bit       req_fired = 1'b0;
   int       send_gap = 0;
   int       send_calm = 0;
   int       stall_left = 0;
   int       stall_calm = 0;

   // Line walker state mirrored from the block
   bit        line_busy;
   bit        straight_line;
   coord_type pos_x, pos_y, end_x, end_y;
   span_type  span_x, span_y;
   bit        dir_x_neg, dir_y_neg;
   err_type   walk_err;
   color_type held_color;

   line_pixel_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_line_color  (req_line_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   always #2 clock = ~clock;

   function automatic void clear_walker();
      line_busy = 1'b0;
      straight_line = 1'b0;
      pos_x = '0;
      pos_y = '0;
      end_x = '0;
      end_y = '0;
      span_x = '0;
      span_y = '0;
      dir_x_neg = 1'b0;
      dir_y_neg = 1'b0;
      walk_err = '0;
      held_color = '0;
   endfunction

   // Next pixel of the line for one request; returns 1 when a pixel comes out
   function automatic bit next_line_pixel(input req_type r, output pix_type p);
      int sx, sy, e2;
      coord_type px, py;
      p = '0;
      if (r.func == FUNC_START) begin
         held_color = r.line_color;
         dir_x_neg = r.x_end < r.x_start;
         dir_y_neg = r.y_end < r.y_start;
         span_x = span_type'(dir_x_neg ? int'(r.x_start) - int'(r.x_end)
                                       : int'(r.x_end) - int'(r.x_start));
         span_y = span_type'(dir_y_neg ? int'(r.y_start) - int'(r.y_end)
                                       : int'(r.y_end) - int'(r.y_start));
         if (r.x_start == r.x_end || r.y_start == r.y_end) begin
            // straight line runs from the smaller coordinate upward
            straight_line = 1'b1;
            pos_x = dir_x_neg ? r.x_end : r.x_start;
            end_x = dir_x_neg ? r.x_start : r.x_end;
            pos_y = dir_y_neg ? r.y_end : r.y_start;
            end_y = dir_y_neg ? r.y_start : r.y_end;
            walk_err = '0;
            line_busy = !(pos_x == end_x && pos_y == end_y);
            p.x = pos_x;
            p.y = pos_y;
            p.last = !line_busy;
         end else begin
            // sloped line: end point first, then walk from the start point
            straight_line = 1'b0;
            pos_x = r.x_start;
            pos_y = r.y_start;
            end_x = r.x_end;
            end_y = r.y_end;
            walk_err = err_type'(int'(span_x) - int'(span_y));
            line_busy = 1'b1;
            p.x = r.x_end;
            p.y = r.y_end;
            p.last = 1'b0;
         end
         p.color = held_color;
         return 1'b1;
      end
      if (!line_busy)
         return 1'b0;
      if (straight_line) begin
         if (pos_x != end_x)
            pos_x = pos_x + coord_type'(1);
         else
            pos_y = pos_y + coord_type'(1);
         line_busy = !(pos_x == end_x && pos_y == end_y);
         p.x = pos_x;
         p.y = pos_y;
      end else begin
         px = pos_x;
         py = pos_y;
         sx = int'(span_x);
         sy = int'(span_y);
         e2 = 2 * int'(walk_err);
         if (e2 > -sy) begin
            walk_err = err_type'(int'(walk_err) - sy);
            pos_x = dir_x_neg ? pos_x - coord_type'(1) : pos_x + coord_type'(1);
         end
         if (e2 < sx) begin
            walk_err = err_type'(int'(walk_err) + sx);
            pos_y = dir_y_neg ? pos_y - coord_type'(1) : pos_y + coord_type'(1);
         end
         line_busy = !(pos_x == end_x && pos_y == end_y);
         p.x = px;
         p.y = py;
      end
      p.color = held_color;
      p.last = !line_busy;
      return 1'b1;
   endfunction

   // Idle length: mostly none or short, a few long, with calm stretches
   function automatic int idle_cycles(inout int calm);
      int pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 59) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int rand_coord();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? 2047 : -2048;
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   function automatic int rand_delta(input int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < -2048)
         return -2048;
      if (v > 2047)
         return 2047;
      return v;
   endfunction

   function automatic int abs_int(input int v);
      return v < 0 ? -v : v;
   endfunction

   task automatic push_start(input int xs, ys, xe, ye, input int color, input bit hold);
      stim_type s;
      s.req.func = FUNC_START;
      s.req.x_start = coord_type'(xs);
      s.req.y_start = coord_type'(ys);
      s.req.x_end = coord_type'(xe);
      s.req.y_end = coord_type'(ye);
      s.req.line_color = color_type'(color);
      s.hold_off = hold;
      pending_reqs.push_back(s);
   endtask

   // Advance with random don't-care payload
   task automatic push_advance();
      stim_type s;
      s.req.func = FUNC_ADVANCE;
      s.req.x_start = coord_type'($urandom);
      s.req.y_start = coord_type'($urandom);
      s.req.x_end = coord_type'($urandom);
      s.req.y_end = coord_type'($urandom);
      s.req.line_color = color_type'($urandom);
      s.hold_off = 1'b0;
      pending_reqs.push_back(s);
   endtask

   // One random line: mostly complete walks, some aborted, some noise
   task automatic push_random_line(inout int counted);
      int kind, xs, ys, xe, ye, len, adv;
      kind = $urandom_range(0, 99);
      xs = rand_coord();
      ys = rand_coord();
      xe = xs;
      ye = ys;
      if (kind >= 95) begin
         adv = $urandom_range(0, 3);
         repeat (adv) push_advance();
         return;
      end
      if (kind >= 5 && kind < 20)
         xe = clamp_coord(xs + rand_delta(20));
      else if (kind >= 20 && kind < 35)
         ye = clamp_coord(ys + rand_delta(20));
      else if (kind >= 35 && kind < 90) begin
         xe = clamp_coord(xs + rand_delta(24));
         ye = clamp_coord(ys + rand_delta(24));
      end else if (kind >= 90) begin
         xe = rand_coord();
         ye = rand_coord();
      end
      len = abs_int(xe - xs) > abs_int(ye - ys) ? abs_int(xe - xs) : abs_int(ye - ys);
      if (kind >= 90)
         adv = $urandom_range(1, 8);
      else if ($urandom_range(0, 99) < 85)
         adv = len + $urandom_range(0, 1);
      else
         adv = $urandom_range(0, len);
      push_start(xs, ys, xe, ye, $urandom_range(0, 65535), $urandom_range(0, 29) == 0);
      repeat (adv) push_advance();
      counted += 1 + (adv < len ? adv : len);
   endtask

   // Request driver
   always @(negedge clock) begin
      stim_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_reqs[0].hold_off && expected_pixels.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            s = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_func <= s.req.func;
            req_x_start <= s.req.x_start;
            req_y_start <= s.req.y_start;
            req_x_end <= s.req.x_end;
            req_y_end <= s.req.y_end;
            req_line_color <= s.req.line_color;
            send_gap = idle_cycles(send_calm);
         end
      end
   end

   // Result backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_cycles(stall_calm);
      end
   end

   // Monitor: predict on request transactions, check pixel transactions
   always @(posedge clock) begin
      req_type r;
      pix_type p;
      pix_type want;
      if (reset) begin
         clear_walker();
         expected_pixels.delete();
         req_fired <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            r.func = req_func;
            r.x_start = req_x_start;
            r.y_start = req_y_start;
            r.x_end = req_x_end;
            r.y_end = req_y_end;
            r.line_color = req_line_color;
            if (next_line_pixel(r, p))
               expected_pixels.push_back(p);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel at (%0d, %0d)", rsp_pixel_x, rsp_pixel_y);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x) begin
                  $error("pixel_x: expected %0d, got %0d", want.x, rsp_pixel_x);
                  error_count++;
               end
               if (rsp_pixel_y !== want.y) begin
                  $error("pixel_y: expected %0d, got %0d", want.y, rsp_pixel_y);
                  error_count++;
               end
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color: expected %h, got %h", want.color, rsp_pixel_color);
                  error_count++;
               end
               if (rsp_last_pixel !== want.last) begin
                  $error("last_pixel: expected %b, got %b", want.last, rsp_last_pixel);
                  error_count++;
               end
            end
         end
         // watchdog on handshake activity
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_line_pixel_generator failed");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      counted = 0;

      // Directed: idle advance, single point, straight lines, sloped lines, aborts
      push_advance();
      push_start(-2048, 2047, -2048, 2047, 16'hFFFF, 1'b0);
      push_advance();
      push_start(5, 3, 1, 3, 16'h0000, 1'b0);
      repeat (4) push_advance();
      push_advance();
      push_start(0, -2, 0, 2, 16'hA5A5, 1'b0);
      push_advance();
      push_start(-2048, -2048, 2047, 2047, 16'h5A5A, 1'b0);
      repeat (2) push_advance();
      push_start(2047, -2048, -2048, 2047, 16'hF800, 1'b0);
      push_advance();
      push_start(3, 7, -2, 1, 16'h07E0, 1'b0);
      repeat (6) push_advance();
      push_start(-2048, 0, 2047, 0, 16'h001F, 1'b1);
      push_advance();

      while (counted < RANDOM_ITEMS)
         push_random_line(counted);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_pixels.size() != 0) begin
         $error("%0d pixels never arrived", expected_pixels.size());
         error_count++;
      end
      if (error_count == 0)
         $display("tb_line_pixel_generator passed");
      else
         $display("tb_line_pixel_generator failed");
      $finish;
   end

endmodule

// File: sim.f
src/lpg_pkg.sv
src/lpg_input_reg.sv
src/lpg_core.sv
src/line_pixel_generator.sv
dv/tb_line_pixel_generator.sv
